/* src/ksmt_pkg.sv */
// ----------------------------------------------------------------------------
// ksmt_pkg
// Shared types and constants for the key scan and motor trigger controller.
// ----------------------------------------------------------------------------
package ksmt_pkg;

   localparam int unsigned PressWidth   = 16;
   localparam int unsigned TimerWidth   = 8;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned NumKeys      = 4;

   typedef logic [PressWidth-1:0] press_cnt_type;
   typedef logic [TimerWidth-1:0] timer_type;

   typedef enum logic [1:0] {
      DRIVE_STOP  = 2'd0,
      DRIVE_FWD   = 2'd1,
      DRIVE_BACK  = 2'd2,
      DRIVE_BRAKE = 2'd3
   } drive_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SHORT_PRESS = 3'd0,
      CSR_LONG_PRESS  = 3'd1,
      CSR_INCH_ON     = 3'd2,
      CSR_INCH_GAP    = 3'd3,
      CSR_BRAKE       = 3'd4,
      CSR_REVERSE     = 3'd5
   } csr_index_type;

   localparam press_cnt_type ShortPressReset = 16'd2;
   localparam press_cnt_type LongPressReset  = 16'd70;
   localparam timer_type     InchOnReset     = 8'd50;
   localparam timer_type     InchGapReset    = 8'd50;
   localparam timer_type     BrakeReset      = 8'd20;
   localparam timer_type     ReverseReset    = 8'd20;
   localparam timer_type     BackoffReset    = 8'd255;

   typedef struct packed {
      press_cnt_type short_press_ticks;
      press_cnt_type long_press_ticks;
      timer_type     inch_on_ticks;
      timer_type     inch_gap_ticks;
      timer_type     brake_ticks;
      timer_type     reverse_ticks;
   } cfg_type;

   typedef struct packed {
      logic mode_key;
      logic rep_key;
      logic reverse_key;
      logic run_key;
   } keys_type;

   typedef struct packed {
      drive_type motor_cmd;
      logic      run_mode;
      logic      repeat_on;
   } result_type;

endpackage

/* src/ksmt_csr.sv */
// ----------------------------------------------------------------------------
// ksmt_csr
// Configuration registers; one write beat per cycle, unknown indexes dropped.
// ----------------------------------------------------------------------------
module ksmt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ksmt_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [ksmt_pkg::CsrDataWidth-1:0] csr_wdata,
   output ksmt_pkg::cfg_type                 cfg
);
   import ksmt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SHORT_PRESS: cfg_in.short_press_ticks = csr_wdata;
            CSR_LONG_PRESS:  cfg_in.long_press_ticks  = csr_wdata;
            CSR_INCH_ON:     cfg_in.inch_on_ticks     = csr_wdata[TimerWidth-1:0];
            CSR_INCH_GAP:    cfg_in.inch_gap_ticks    = csr_wdata[TimerWidth-1:0];
            CSR_BRAKE:       cfg_in.brake_ticks       = csr_wdata[TimerWidth-1:0];
            CSR_REVERSE:     cfg_in.reverse_ticks     = csr_wdata[TimerWidth-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_press_ticks <= ShortPressReset;
         cfg_ff.long_press_ticks  <= LongPressReset;
         cfg_ff.inch_on_ticks     <= InchOnReset;
         cfg_ff.inch_gap_ticks    <= InchGapReset;
         cfg_ff.brake_ticks       <= BrakeReset;
         cfg_ff.reverse_ticks     <= ReverseReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/ksmt_ctrl.sv */
// ----------------------------------------------------------------------------
// ksmt_ctrl
// Key press counters, mode bits and drive timers, updated once per tick.
// ----------------------------------------------------------------------------
module ksmt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  ksmt_pkg::keys_type   keys,
   input  ksmt_pkg::cfg_type    cfg,
   output ksmt_pkg::result_type result
);
   import ksmt_pkg::*;

   press_cnt_type press_ff [NumKeys];
   press_cnt_type press_in [NumKeys];
   timer_type     inch_ff, inch_in;
   timer_type     backoff_ff, backoff_in;
   logic          mode_ff, mode_in;
   logic          rep_ff, rep_in;
   drive_type     drive_ff, drive_in;

   function automatic press_cnt_type press_inc(input press_cnt_type c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic timer_type timer_inc(input timer_type t);
      return (t == '1) ? t : t + 1'b1;
   endfunction

   always_comb begin
      logic                tog_mode;
      logic                tog_rep;
      logic [TimerWidth:0] pulse_len;
      logic [TimerWidth:0] backoff_len;
      timer_type           inch_next;
      timer_type           backoff_next;

      tog_mode     = 1'b0;
      tog_rep      = 1'b0;
      pulse_len    = {1'b0, cfg.inch_on_ticks} + {1'b0, cfg.inch_gap_ticks};
      backoff_len  = {1'b0, cfg.brake_ticks} + {1'b0, cfg.reverse_ticks};
      inch_next    = timer_inc(inch_ff);
      backoff_next = timer_inc(backoff_ff);
      press_in     = press_ff;
      inch_in      = inch_ff;
      backoff_in   = backoff_ff;
      drive_in     = drive_ff;

      // Toggle keys act on release, judged by the count held before release.
      if (keys.mode_key) begin
         press_in[0] = press_inc(press_ff[0]);
      end else begin
         tog_mode    = press_ff[0] >= cfg.short_press_ticks;
         press_in[0] = '0;
      end
      if (keys.rep_key) begin
         press_in[1] = press_inc(press_ff[1]);
      end else begin
         tog_rep     = press_ff[1] >= cfg.short_press_ticks;
         press_in[1] = '0;
      end

      if (keys.reverse_key) begin
         press_in[2] = press_inc(press_ff[2]);
         if (press_in[2] >= cfg.long_press_ticks) begin
            drive_in = DRIVE_BACK;
         end
      end else begin
         press_in[2] = '0;
      end

      // A run key held for at least the short press time overrides whatever the reverse key set in this tick.
      if (keys.run_key) begin
         press_in[3] = press_inc(press_ff[3]);
         if (press_in[3] >= cfg.short_press_ticks) begin
            if (mode_ff) begin
               drive_in = DRIVE_FWD;
            end else begin
               inch_in  = inch_next;
               drive_in = (inch_next <= cfg.inch_on_ticks) ? DRIVE_FWD : DRIVE_STOP;
               if (rep_ff && ({1'b0, inch_next} > pulse_len)) begin
                  inch_in = '0;
               end
            end
            backoff_in = '0;
         end
      end else begin
         press_in[3] = '0;
         inch_in     = '0;
         backoff_in  = backoff_next;
         priority if (backoff_next <= cfg.brake_ticks) begin
            drive_in = DRIVE_BRAKE;
         end else if ({1'b0, backoff_next} <= backoff_len) begin
            drive_in = DRIVE_BACK;
         end else if (!keys.reverse_key) begin
            drive_in = DRIVE_STOP;
         end
      end

      mode_in = mode_ff ^ tog_mode;
      rep_in  = rep_ff ^ tog_rep;

      result.motor_cmd = drive_in;
      result.run_mode  = mode_in;
      result.repeat_on = rep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumKeys; i++) begin
            press_ff[i] <= '0;
         end
         inch_ff    <= '0;
         backoff_ff <= BackoffReset;
         mode_ff    <= 1'b1;
         rep_ff     <= 1'b0;
         drive_ff   <= DRIVE_STOP;
      end else if (step_en) begin
         press_ff   <= press_in;
         inch_ff    <= inch_in;
         backoff_ff <= backoff_in;
         mode_ff    <= mode_in;
         rep_ff     <= rep_in;
         drive_ff   <= drive_in;
      end
   end

endmodule

/* src/key_scan_motor_trigger_control_core.sv */
// ----------------------------------------------------------------------------
// key_scan_motor_trigger_control_core
// Key scanner and motor trigger controller, one scan tick per request beat.
//
// Each request beat carries one scan tick of four key levels and yields one
// response beat with the motor command and the two mode flags after that
// tick. The block takes one beat per clock while the request side is not
// stalled: the beat is captured in an input register, and once the
// response register is free or being taken, the counter and timer update
// for that tick runs in one pass and loads the response register. A stalled
// response holds the input register, and the request side is stalled only when both are full.
// Configuration writes are taken at any time but belong to idle periods.
// ----------------------------------------------------------------------------
module key_scan_motor_trigger_control_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode_key,
   input  logic                              req_repeat_key,
   input  logic                              req_reverse_key,
   input  logic                              req_run_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_motor_cmd,
   output logic                              rsp_run_mode,
   output logic                              rsp_repeat_on,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ksmt_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [ksmt_pkg::CsrDataWidth-1:0] csr_wdata
);
   import ksmt_pkg::*;

   cfg_type    cfg;
   keys_type   keys_ff;
   logic       in_vld_ff;
   logic       out_vld_ff;
   result_type out_ff;
   result_type step_result;
   logic       advance;
   logic       req_take;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ksmt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ksmt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .keys    (keys_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         keys_ff.mode_key    <= req_mode_key;
         keys_ff.rep_key     <= req_repeat_key;
         keys_ff.reverse_key <= req_reverse_key;
         keys_ff.run_key     <= req_run_key;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_motor_cmd = out_ff.motor_cmd;
   assign rsp_run_mode  = out_ff.run_mode;
   assign rsp_repeat_on = out_ff.repeat_on;

   // A tick that leaves the input register always shows up as a response.
   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed tick did not produce a response beat");

   // The request side is held off only when both registers are occupied.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff && rsp_stall))
      else $error("request stalled while a register was free");

   // A taken response with nothing pending leaves the output empty.
   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_vld_ff) |=> !rsp_valid)
      else $error("response beat appeared without a tick");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key scan and motor trigger controller.
//
// Each request beat is one scan tick of four key levels. A behavioral copy of
// the key counters, inching and back-off timers and the two mode flags runs
// alongside the block and queues the response that every accepted tick must
// produce. A short scripted opening is followed by several register settings
// (reset values, small values, all zero, large sums, full-scale thresholds)
// with random hold patterns, and a run with every key held against
// full-scale thresholds. Both sides insert random gaps, and one long
// response stall backs the block up into its request side.
// ----------------------------------------------------------------------------
module tb_top;
   import ksmt_pkg::*;

   localparam int HalfPeriod      = 2;
   localparam int ResetCycles     = 7;
   localparam int DrainCycles     = 6;
   localparam int LongHoldCycles  = 80;
   localparam int WatchdogLimit   = 1000;
   localparam int MaxReports      = 10;
   localparam int DirectedRows    = 18;
   localparam int SoakTicks       = 100;

   localparam int unsigned SlotMode    = 0;
   localparam int unsigned SlotRepeat  = 1;
   localparam int unsigned SlotReverse = 2;
   localparam int unsigned SlotRun     = 3;

   // Register indexes that decode to nothing.
   localparam logic [CsrIdxWidth-1:0] CsrSpareLow  = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CsrSpareHigh = 3'd7;

   // Key masks in the bit order of keys_type: mode, repeat, reverse, run.
   localparam logic [3:0] KeysNone = 4'b0000;
   localparam logic [3:0] KeyRun   = 4'b0001;
   localparam logic [3:0] KeyRev   = 4'b0010;
   localparam logic [3:0] KeyRep   = 4'b0100;
   localparam logic [3:0] KeyMode  = 4'b1000;
   localparam logic [3:0] KeysAll  = 4'b1111;

   localparam result_type StopInRunMode  = '{DRIVE_STOP, 1'b1, 1'b0};
   localparam result_type FwdInRunMode   = '{DRIVE_FWD, 1'b1, 1'b0};
   localparam result_type BrakeInRunMode = '{DRIVE_BRAKE, 1'b1, 1'b0};
   localparam result_type NoWant         = '0;

   typedef struct packed {
      logic [3:0] keys;
      logic [7:0] hold;
      logic       known;
      result_type want;
   } script_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_mode_key;
   logic                    req_repeat_key;
   logic                    req_reverse_key;
   logic                    req_run_key;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [1:0]              rsp_motor_cmd;
   logic                    rsp_run_mode;
   logic                    rsp_repeat_on;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   // Behavioral copy of the controller.
   cfg_type       pred_cfg;
   press_cnt_type key_held [NumKeys];
   timer_type     inch_cnt;
   timer_type     backoff_cnt;
   logic          mode_q;
   logic          repeat_q;
   drive_type     drive_q;

   result_type     replies_due [$];
   script_row_type script [DirectedRows];
   int unsigned    ticks_sent;
   int unsigned    fail_count;
   int unsigned    quiet_cycles;
   bit             idle_on;
   bit             long_hold_pending;

   key_scan_motor_trigger_control_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode_key    (req_mode_key),
      .req_repeat_key  (req_repeat_key),
      .req_reverse_key (req_reverse_key),
      .req_run_key     (req_run_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_motor_cmd   (rsp_motor_cmd),
      .rsp_run_mode    (rsp_run_mode),
      .rsp_repeat_on   (rsp_repeat_on),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #HalfPeriod clock = ~clock;

   // ----------------------------------------------------------------------
   // Prediction
   // ----------------------------------------------------------------------
   function automatic void clear_controller();
      pred_cfg = '{ShortPressReset, LongPressReset, InchOnReset, InchGapReset,
                   BrakeReset, ReverseReset};
      foreach (key_held[i]) key_held[i] = '0;
      inch_cnt    = '0;
      backoff_cnt = BackoffReset;
      mode_q      = 1'b1;
      repeat_q    = 1'b0;
      drive_q     = DRIVE_STOP;
   endfunction

   function automatic void bump_press(input int unsigned slot);
      if (key_held[slot] != '1) key_held[slot] = key_held[slot] + 1'b1;
   endfunction

   // Returns 1 when a held toggle key is let go after at least the short time.
   function automatic logic toggle_released(input int unsigned slot, input logic pressed);
      logic fire;
      fire = 1'b0;
      if (pressed) begin
         bump_press(slot);
      end else begin
         fire = (key_held[slot] >= pred_cfg.short_press_ticks);
         key_held[slot] = '0;
      end
      return fire;
   endfunction

   task automatic step_motor_tick(input keys_type k, output result_type r);
      logic flip_mode;
      logic flip_rep;
      flip_mode = toggle_released(SlotMode, k.mode_key);
      flip_rep  = toggle_released(SlotRepeat, k.rep_key);

      if (k.reverse_key) begin
         bump_press(SlotReverse);
         if (key_held[SlotReverse] >= pred_cfg.long_press_ticks) drive_q = DRIVE_BACK;
      end else begin
         key_held[SlotReverse] = '0;
      end

      if (k.run_key) begin
         bump_press(SlotRun);
         if (key_held[SlotRun] >= pred_cfg.short_press_ticks) begin
            if (mode_q) begin
               drive_q = DRIVE_FWD;
            end else begin
               if (inch_cnt != '1) inch_cnt = inch_cnt + 1'b1;
               drive_q = (inch_cnt <= pred_cfg.inch_on_ticks) ? DRIVE_FWD : DRIVE_STOP;
               // The pulse period sum can exceed the 8-bit timer range.
               if (repeat_q && int'(inch_cnt) >
                   int'(pred_cfg.inch_on_ticks) + int'(pred_cfg.inch_gap_ticks)) begin
                  inch_cnt = '0;
               end
            end
            backoff_cnt = '0;
         end
      end else begin
         key_held[SlotRun] = '0;
         inch_cnt = '0;
         if (backoff_cnt != '1) backoff_cnt = backoff_cnt + 1'b1;
         if (backoff_cnt <= pred_cfg.brake_ticks) begin
            drive_q = DRIVE_BRAKE;
         end else if (int'(backoff_cnt) <=
                      int'(pred_cfg.brake_ticks) + int'(pred_cfg.reverse_ticks)) begin
            drive_q = DRIVE_BACK;
         end else if (!k.reverse_key) begin
            drive_q = DRIVE_STOP;
         end
      end

      if (flip_mode) mode_q = ~mode_q;
      if (flip_rep) repeat_q = ~repeat_q;
      r.motor_cmd = drive_q;
      r.run_mode  = mode_q;
      r.repeat_on = repeat_q;
   endtask

   // ----------------------------------------------------------------------
   // Request side and register writes; all entered at a falling edge.
   // ----------------------------------------------------------------------
   task automatic send_keys(input keys_type k, input logic known, input result_type want);
      int unsigned gap;
      result_type  model;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode_key    <= k.mode_key;
      req_repeat_key  <= k.rep_key;
      req_reverse_key <= k.reverse_key;
      req_run_key     <= k.run_key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_motor_tick(k, model);
      replies_due.push_back(known ? want : model);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SHORT_PRESS: pred_cfg.short_press_ticks = data;
         CSR_LONG_PRESS:  pred_cfg.long_press_ticks  = data;
         CSR_INCH_ON:     pred_cfg.inch_on_ticks     = data[7:0];
         CSR_INCH_GAP:    pred_cfg.inch_gap_ticks    = data[7:0];
         CSR_BRAKE:       pred_cfg.brake_ticks       = data[7:0];
         CSR_REVERSE:     pred_cfg.reverse_ticks     = data[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Upper bits of the 8-bit registers carry junk that must be dropped, and
   // the spare indexes go last so that a stray decode would stick.
   task automatic load_settings(input cfg_type c);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_reg(CSR_SHORT_PRESS, c.short_press_ticks);
      write_reg(CSR_LONG_PRESS, c.long_press_ticks);
      write_reg(CSR_INCH_ON, {junk[15:8], c.inch_on_ticks});
      write_reg(CSR_INCH_GAP, {junk[7:0], c.inch_gap_ticks});
      write_reg(CSR_BRAKE, {junk[11:4], c.brake_ticks});
      write_reg(CSR_REVERSE, {~junk[15:8], c.reverse_ticks});
      write_reg(CsrSpareLow, junk);
      write_reg(CsrSpareHigh, ~junk);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // One hold pattern: a key combination held for a number of ticks, or a
   // short burst of random levels.
   task automatic play_hold(input int unsigned max_hold);
      keys_type    k;
      logic [3:0]  noise;
      int unsigned len;
      int unsigned pick;
      bit          churn;
      k     = '0;
      churn = 1'b0;
      pick  = $urandom_range(0, 99);
      if (pick < 40) begin
         k.run_key = 1'b1;
         len = $urandom_range(1, max_hold);
      end else if (pick < 55) begin
         len = $urandom_range(1, max_hold);
      end else if (pick < 70) begin
         k.mode_key = 1'($urandom_range(0, 1));
         k.rep_key  = 1'($urandom_range(0, 1));
         len = $urandom_range(1, int'(pred_cfg.short_press_ticks) + 3);
      end else if (pick < 80) begin
         k.reverse_key = 1'b1;
         k.run_key     = ($urandom_range(0, 3) == 0);
         len = $urandom_range(1, int'(pred_cfg.long_press_ticks) + 5);
      end else begin
         churn = 1'b1;
         len = $urandom_range(1, 8);
      end
      repeat (len) begin
         if (churn) begin
            noise = 4'($urandom_range(0, 15));
            k = noise;
         end
         send_keys(k, 1'b0, NoWant);
      end
   endtask

   task automatic random_ticks(input int unsigned budget, input int unsigned max_hold);
      int unsigned start;
      start = ticks_sent;
      while (ticks_sent - start < budget) begin
         idle_on = ($urandom_range(0, 3) != 0);
         play_hold(max_hold);
      end
   endtask

   // ----------------------------------------------------------------------
   // Response side
   // ----------------------------------------------------------------------
   initial begin : reply_side
      int unsigned wait_cycles;
      result_type  want;
      rsp_stall = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         wait_cycles = idle_on ? $urandom_range(0, 5) : 0;
         if (long_hold_pending) begin
            wait_cycles = LongHoldCycles;
            long_hold_pending = 1'b0;
         end
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (replies_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MaxReports)
               $display("tb_top: response beat with nothing outstanding: cmd %0d mode %0d rep %0d",
                        rsp_motor_cmd, rsp_run_mode, rsp_repeat_on);
         end else begin
            want = replies_due.pop_front();
            if (rsp_motor_cmd !== want.motor_cmd || rsp_run_mode !== want.run_mode ||
                rsp_repeat_on !== want.repeat_on) begin
               fail_count++;
               if (fail_count <= MaxReports)
                  $display("tb_top: mismatch: cmd %0d/%0d mode %0d/%0d rep %0d/%0d (got/want)",
                           rsp_motor_cmd, want.motor_cmd, rsp_run_mode, want.run_mode,
                           rsp_repeat_on, want.repeat_on);
            end
         end
         @(negedge clock);
      end
   end

   // Ends the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // ----------------------------------------------------------------------
   // Main sequence
   // ----------------------------------------------------------------------
   initial begin : stimulus
      cfg_type c;
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode_key      = 1'b0;
      req_repeat_key    = 1'b0;
      req_reverse_key   = 1'b0;
      req_run_key       = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      ticks_sent        = 0;
      fail_count        = 0;
      quiet_cycles      = 0;
      idle_on           = 1'b1;
      long_hold_pending = 1'b0;
      clear_controller();

      // Opening script at reset settings: motor start after the short time,
      // brake on release, single and joint toggles, a press too short to
      // toggle, the run key overriding the reverse key, and a mode change
      // that only reaches the run key on the following tick.
      script = '{
         '{KeysNone,               8'd1, 1'b1, StopInRunMode},
         '{KeyRun,                 8'd1, 1'b1, StopInRunMode},
         '{KeyRun,                 8'd1, 1'b1, FwdInRunMode},
         '{KeysNone,               8'd1, 1'b1, BrakeInRunMode},
         '{KeyMode,                8'd2, 1'b0, NoWant},
         '{KeysNone,               8'd1, 1'b0, NoWant},
         '{KeyRep,                 8'd2, 1'b0, NoWant},
         '{KeysNone,               8'd1, 1'b0, NoWant},
         '{KeyMode | KeyRep,       8'd1, 1'b0, NoWant},
         '{KeysNone,               8'd1, 1'b0, NoWant},
         '{KeyMode | KeyRep,       8'd2, 1'b0, NoWant},
         '{KeysNone,               8'd1, 1'b0, NoWant},
         '{KeyRev,                 8'd1, 1'b0, NoWant},
         '{KeyRev | KeyRun,        8'd3, 1'b0, NoWant},
         '{KeysAll,                8'd2, 1'b0, NoWant},
         '{KeysNone,               8'd1, 1'b0, NoWant},
         '{KeyMode | KeyRun,       8'd2, 1'b0, NoWant},
         '{KeyRun,                 8'd1, 1'b0, NoWant}
      };

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[r]) begin
         repeat (script[r].hold) send_keys(script[r].keys, script[r].known, script[r].want);
      end
      random_ticks(100, 60);
      settle();

      // Small random settings; the long response stall lands here.
      c.short_press_ticks = 16'($urandom_range(1, 4));
      c.long_press_ticks  = 16'($urandom_range(1, 12));
      c.inch_on_ticks     = 8'($urandom_range(0, 8));
      c.inch_gap_ticks    = 8'($urandom_range(0, 8));
      c.brake_ticks       = 8'($urandom_range(0, 6));
      c.reverse_ticks     = 8'($urandom_range(0, 6));
      load_settings(c);
      random_ticks(100, 30);
      idle_on = 1'b0;
      long_hold_pending = 1'b1;
      repeat (LongHoldCycles / 2) send_keys('0, 1'b0, NoWant);
      random_ticks(200, 30);
      settle();

      // All thresholds zero: a release with nothing counted still toggles.
      load_settings('0);
      random_ticks(200, 10);
      settle();

      // Sums beyond the timer range: no pulse restart, endless back-off.
      c = '{16'd1, 16'd1, 8'd255, 8'd255, 8'd254, 8'd254};
      load_settings(c);
      random_ticks(400, 300);
      settle();

      c.short_press_ticks = 16'($urandom_range(1, 3));
      c.long_press_ticks  = 16'($urandom_range(1, 20));
      c.inch_on_ticks     = 8'($urandom_range(200, 255));
      c.inch_gap_ticks    = 8'($urandom_range(0, 100));
      c.brake_ticks       = 8'($urandom_range(0, 254));
      c.reverse_ticks     = 8'($urandom_range(0, 254));
      load_settings(c);
      random_ticks(300, 300);
      settle();

      // Full-scale thresholds: every key held, none reaches its limit, then
      // a release long enough to saturate the back-off timer.
      c = '{16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 8'd254, 8'd1};
      load_settings(c);
      idle_on = 1'b0;
      repeat (SoakTicks) send_keys(KeysAll, 1'b0, NoWant);
      repeat (300) send_keys(KeysNone, 1'b0, NoWant);
      repeat (3) send_keys(KeyMode | KeyRep, 1'b0, NoWant);
      repeat (3) send_keys(KeysNone, 1'b0, NoWant);
      idle_on = 1'b1;
      settle();

      c = '{ShortPressReset, LongPressReset, InchOnReset, InchGapReset,
            BrakeReset, ReverseReset};
      load_settings(c);
      random_ticks(150, 100);
      settle();

      if (replies_due.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
